FILE: src/fpd_pkg.sv
// Shared constants, codes and types for the fountain peeling decoder.
// Used by fpd_engine and fountain_peeling_decoder; depends on nothing.
package fpd_pkg;

  localparam int MAX_PARTS    = 64;
  localparam int FRAGMENT_MAX = 1024;
  localparam int MIXED_SLOTS  = 16;

  localparam int PC_W    = 7;
  localparam int FL_W    = 11;
  localparam int IDX_W   = $clog2(MAX_PARTS);
  localparam int POS_W   = $clog2(FRAGMENT_MAX);
  localparam int SLOT_W  = $clog2(MIXED_SLOTS + 1);
  localparam int MS_W    = (MIXED_SLOTS > 1) ? $clog2(MIXED_SLOTS) : 1;
  localparam int FRAG_DEPTH = MAX_PARTS * FRAGMENT_MAX;
  localparam int FRAG_AW    = $clog2(FRAG_DEPTH);
  localparam int WORK_DEPTH = (MIXED_SLOTS + 1) * FRAGMENT_MAX;
  localparam int WORK_AW    = SLOT_W + POS_W;
  localparam int PART_SLOT  = MIXED_SLOTS;

  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_REDUNDANT = 2'd1;
  localparam logic [1:0] ST_COMPLETE  = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

  localparam logic CFG_PART_COUNT = 1'b0;
  localparam logic CFG_FRAG_LEN   = 1'b1;

  typedef enum logic [1:0] {
    OP_XOR  = 2'd0,
    OP_HOLD = 2'd1,
    OP_MOVE = 2'd2
  } eng_op_t;

  typedef struct packed {
    logic              start;
    eng_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] src_slot;
    logic [SLOT_W-1:0] dst_slot;
  } eng_cmd_t;

  typedef struct packed {
    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic [7:0]         wr_data;
    logic [FRAG_AW-1:0] rd_addr;
  } host_port_t;

endpackage

FILE: src/fpd_engine.sv
// Byte mover for the peeling decoder: holds the fragment store and the work
// store (mixed slots plus the incoming part buffer). Depends on fpd_pkg.
module fpd_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  fpd_pkg::eng_cmd_t             cmd,
  input  logic [fpd_pkg::FL_W-1:0]      fl,
  input  fpd_pkg::host_port_t           host,
  output logic                          busy,
  output logic [7:0]                    rd_data
);

  logic [7:0] frag_mem [fpd_pkg::FRAG_DEPTH];
  logic [7:0] work_mem [fpd_pkg::WORK_DEPTH];

  logic                            phase;
  logic [fpd_pkg::POS_W-1:0]       j;
  logic [fpd_pkg::FRAG_AW-1:0]     base;
  fpd_pkg::eng_op_t                op;
  logic [fpd_pkg::SLOT_W-1:0]      src;
  logic [fpd_pkg::SLOT_W-1:0]      dst;
  logic [7:0]                      fr_q;
  logic [7:0]                      wk_q;

  logic [fpd_pkg::FRAG_AW-1:0]     fr_raddr;
  logic [fpd_pkg::FRAG_AW-1:0]     eng_faddr;
  logic [fpd_pkg::WORK_AW-1:0]     wk_raddr;
  logic                            wk_we;
  logic [fpd_pkg::WORK_AW-1:0]     wk_waddr;
  logic [7:0]                      wk_wdata;
  logic                            fr_we;
  logic [fpd_pkg::POS_W-1:0]       j_last;
  logic [fpd_pkg::FL_W+fpd_pkg::IDX_W-1:0] prod;

  assign eng_faddr = base + fpd_pkg::FRAG_AW'(j);
  assign fr_raddr  = busy ? eng_faddr : host.rd_addr;
  assign wk_raddr  = {src, j};
  assign j_last    = fpd_pkg::POS_W'(fl - fpd_pkg::FL_W'(1));
  assign prod      = cmd.idx * fl;
  assign fr_we     = busy && phase && (op == fpd_pkg::OP_HOLD);

  always_comb begin
    wk_we    = host.wr_en;
    wk_waddr = {fpd_pkg::SLOT_W'(fpd_pkg::PART_SLOT), host.wr_pos};
    wk_wdata = host.wr_data;
    if (busy && phase && op != fpd_pkg::OP_HOLD) begin
      wk_we    = 1'b1;
      wk_waddr = {dst, j};
      wk_wdata = (op == fpd_pkg::OP_XOR) ? (wk_q ^ fr_q) : wk_q;
    end
  end

  always_ff @(posedge clk) begin
    fr_q <= frag_mem[fr_raddr];
    wk_q <= work_mem[wk_raddr];
    if (fr_we) begin
      frag_mem[eng_faddr] <= wk_q;
    end
    if (wk_we) begin
      work_mem[wk_waddr] <= wk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (!busy) begin
      if (cmd.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        j     <= '0;
        base  <= fpd_pkg::FRAG_AW'(prod);
        op    <= cmd.op;
        src   <= cmd.src_slot;
        dst   <= cmd.dst_slot;
      end
    end else if (!phase) begin
      phase <= 1'b1;
    end else begin
      // write done this cycle; advance or finish
      phase <= 1'b0;
      if (j == j_last) begin
        busy <= 1'b0;
      end else begin
        j <= j + fpd_pkg::POS_W'(1);
      end
    end
  end

  assign rd_data = fr_q;

endmodule

FILE: src/fountain_peeling_decoder.sv
// Top level of the fountain peeling decoder: handshakes, configuration,
// mask bookkeeping and the peeling sequencer. Depends on fpd_pkg, fpd_engine.
//
// A data byte that is not the last of its part is written straight into the
// part buffer. A part's last byte starts the work: each held fragment in its
// mask is XORed out, the mask bits are scanned (part_count per scan), and a
// resolved fragment is stored or a slot is copied; the peeling walk repeats
// these for every queued part until a full pass resolves nothing. All byte
// work runs through the one byte mover, a byte at a time (read, then write).
// in_ready is low while an item is being worked on.
module fountain_peeling_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [fpd_pkg::FL_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [63:0]               part_mask,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic [15:0]               read_address,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [6:0]                remaining,
  output logic [7:0]                read_byte
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_FINISH    = 15'b000000000000010,
    S_SCAN      = 15'b000000000000100,
    S_XWAIT     = 15'b000000000001000,
    S_DECIDE    = 15'b000000000010000,
    S_HOLD_WAIT = 15'b000000000100000,
    S_MOVE_WAIT = 15'b000000001000000,
    S_PEEL_TOP  = 15'b000000010000000,
    S_PEEL_NEXT = 15'b000000100000000,
    S_PEEL_LOAD = 15'b000001000000000,
    S_REMOVE    = 15'b000010000000000,
    S_REM_LOAD  = 15'b000100000000000,
    S_READ      = 15'b001000000000000,
    S_EMIT      = 15'b010000000000000,
    S_SPARE     = 15'b100000000000000
  } state_t;

  state_t state;

  logic [fpd_pkg::PC_W-1:0]   part_count;
  logic [fpd_pkg::FL_W-1:0]   fragment_length;
  logic [fpd_pkg::PC_W-1:0]   pc_eff;
  logic [fpd_pkg::FL_W-1:0]   fl_eff;
  logic [63:0]                valid_bits;
  logic [fpd_pkg::PC_W+fpd_pkg::FL_W-1:0] total_bytes;

  logic [63:0]                received_mask;
  logic [fpd_pkg::PC_W-1:0]   held;
  logic [fpd_pkg::SLOT_W-1:0] mixed_used;
  logic [fpd_pkg::POS_W-1:0]  byte_position;
  logic                       in_part;
  logic                       overrun;
  logic [63:0]                latched_mask;

  logic [63:0]                cur_mask;
  logic                       bad;
  logic [fpd_pkg::IDX_W-1:0]  i;
  logic [1:0]                 cnt;
  logic [fpd_pkg::IDX_W-1:0]  low;
  logic [fpd_pkg::SLOT_W-1:0] cur_slot;
  logic [fpd_pkg::SLOT_W-1:0] m;
  logic                       peel_mode;
  logic                       progressed;
  logic [1:0]                 status_r;
  logic [7:0]                 rb_r;
  logic                       read_hit;

  logic [63:0]                mixed_masks [fpd_pkg::MIXED_SLOTS];
  logic [63:0]                mm_rdata;
  logic [fpd_pkg::MS_W-1:0]   mm_raddr;
  logic                       mm_we;
  logic [fpd_pkg::MS_W-1:0]   mm_waddr;
  logic [63:0]                mm_wdata;

  fpd_pkg::eng_cmd_t          eng_cmd;
  fpd_pkg::host_port_t        host;
  logic                       eng_busy;
  logic [7:0]                 eng_rd;

  logic                       accept;
  logic                       complete;
  logic                       scan_hit;
  logic                       scan_end;
  logic                       queue_full;
  logic [fpd_pkg::SLOT_W-1:0] used_dec;
  logic [fpd_pkg::FL_W:0]     pos_inc;

  always_comb begin
    if (part_count == '0) begin
      pc_eff = fpd_pkg::PC_W'(1);
    end else if (part_count > fpd_pkg::PC_W'(fpd_pkg::MAX_PARTS)) begin
      pc_eff = fpd_pkg::PC_W'(fpd_pkg::MAX_PARTS);
    end else begin
      pc_eff = part_count;
    end
    if (fragment_length == '0) begin
      fl_eff = fpd_pkg::FL_W'(1);
    end else if (fragment_length > fpd_pkg::FL_W'(fpd_pkg::FRAGMENT_MAX)) begin
      fl_eff = fpd_pkg::FL_W'(fpd_pkg::FRAGMENT_MAX);
    end else begin
      fl_eff = fragment_length;
    end
    for (int k = 0; k < 64; k++) begin
      valid_bits[k] = (8'(k) < {1'b0, pc_eff});
    end
  end

  assign total_bytes = pc_eff * fl_eff;
  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == S_IDLE);
  assign complete    = (held == pc_eff);
  assign scan_hit    = cur_mask[i] && received_mask[i];
  assign scan_end    = ({1'b0, i} == (pc_eff - fpd_pkg::PC_W'(1)));
  assign queue_full  = (mixed_used >= fpd_pkg::SLOT_W'(fpd_pkg::MIXED_SLOTS));
  assign used_dec    = mixed_used - fpd_pkg::SLOT_W'(1);
  assign pos_inc     = {1'b0, fpd_pkg::FL_W'(byte_position)} + (fpd_pkg::FL_W + 1)'(1);
  assign read_hit    = complete &&
                       ({{(fpd_pkg::PC_W + fpd_pkg::FL_W - 16){1'b0}}, read_address}
                        < total_bytes);

  assign host.wr_en   = accept && (func == fpd_pkg::FUNC_DATA);
  assign host.wr_pos  = byte_position;
  assign host.wr_data = data_byte;
  assign host.rd_addr = fpd_pkg::FRAG_AW'(read_address);

  fpd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (eng_cmd),
    .fl      (fl_eff),
    .host    (host),
    .busy    (eng_busy),
    .rd_data (eng_rd)
  );

  always_comb begin
    eng_cmd.start    = 1'b0;
    eng_cmd.op       = fpd_pkg::OP_XOR;
    eng_cmd.idx      = i;
    eng_cmd.src_slot = cur_slot;
    eng_cmd.dst_slot = cur_slot;
    mm_raddr = m[fpd_pkg::MS_W-1:0];
    mm_we    = 1'b0;
    mm_waddr = m[fpd_pkg::MS_W-1:0];
    mm_wdata = cur_mask;
    unique case (state)
      S_SCAN: begin
        eng_cmd.start = scan_hit;
      end
      S_DECIDE: begin
        if (cnt == 2'd1) begin
          eng_cmd.start = 1'b1;
          eng_cmd.op    = fpd_pkg::OP_HOLD;
          eng_cmd.idx   = low;
        end else if (cnt != 2'd0 && !peel_mode && !queue_full) begin
          eng_cmd.start    = 1'b1;
          eng_cmd.op       = fpd_pkg::OP_MOVE;
          eng_cmd.dst_slot = mixed_used;
          mm_we    = 1'b1;
          mm_waddr = mixed_used[fpd_pkg::MS_W-1:0];
        end
        if (peel_mode) begin
          mm_we = 1'b1;
        end
      end
      S_REMOVE: begin
        mm_raddr = used_dec[fpd_pkg::MS_W-1:0];
      end
      S_REM_LOAD: begin
        eng_cmd.start    = 1'b1;
        eng_cmd.op       = fpd_pkg::OP_MOVE;
        eng_cmd.src_slot = mixed_used;
        eng_cmd.dst_slot = m;
        mm_we    = 1'b1;
        mm_wdata = mm_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mm_rdata <= mixed_masks[mm_raddr];
    if (mm_we) begin
      mixed_masks[mm_waddr] <= mm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      part_count      <= fpd_pkg::PC_W'(1);
      fragment_length <= fpd_pkg::FL_W'(1);
      received_mask   <= '0;
      held            <= '0;
      mixed_used      <= '0;
      byte_position   <= '0;
      in_part         <= 1'b0;
      overrun         <= 1'b0;
      latched_mask    <= '0;
      peel_mode       <= 1'b0;
      progressed      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          fpd_pkg::CFG_PART_COUNT: part_count <= cfg_data[fpd_pkg::PC_W-1:0];
          fpd_pkg::CFG_FRAG_LEN:   fragment_length <= cfg_data;
          default: begin
          end
        endcase
        received_mask <= '0;
        held          <= '0;
        mixed_used    <= '0;
        byte_position <= '0;
        in_part       <= 1'b0;
        overrun       <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rb_r <= '0;
          if (accept) begin
            unique case (func)
              fpd_pkg::FUNC_DATA: begin
                if (!in_part) begin
                  latched_mask <= part_mask;
                end
                if (!last_byte) begin
                  in_part <= 1'b1;
                  if (pos_inc >= {1'b0, fl_eff}) begin
                    overrun <= 1'b1;
                  end else begin
                    byte_position <= byte_position + fpd_pkg::POS_W'(1);
                  end
                end else begin
                  cur_mask <= in_part ? latched_mask : part_mask;
                  bad <= overrun ||
                         ({1'b0, fpd_pkg::FL_W'(byte_position)} + (fpd_pkg::FL_W + 1)'(1)
                          != {1'b0, fl_eff});
                  in_part       <= 1'b0;
                  overrun       <= 1'b0;
                  byte_position <= '0;
                  state         <= S_FINISH;
                end
              end
              fpd_pkg::FUNC_READ: begin
                if (read_hit) begin
                  state <= S_READ;
                end else begin
                  status_r <= fpd_pkg::ST_REJECTED;
                  state    <= S_EMIT;
                end
              end
              fpd_pkg::FUNC_CLEAR: begin
                received_mask <= '0;
                held          <= '0;
                mixed_used    <= '0;
                byte_position <= '0;
                in_part       <= 1'b0;
                overrun       <= 1'b0;
                status_r      <= fpd_pkg::ST_ACCEPTED;
                state         <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          rb_r     <= eng_rd;
          status_r <= fpd_pkg::ST_COMPLETE;
          state    <= S_EMIT;
        end
        S_FINISH: begin
          if (complete) begin
            status_r <= fpd_pkg::ST_REDUNDANT;
            state    <= S_EMIT;
          end else if (bad || (cur_mask & ~valid_bits) != '0) begin
            status_r <= fpd_pkg::ST_REJECTED;
            state    <= S_EMIT;
          end else begin
            i         <= '0;
            cnt       <= '0;
            cur_slot  <= fpd_pkg::SLOT_W'(fpd_pkg::PART_SLOT);
            peel_mode <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            // strip this held fragment, then revisit the same bit
            cur_mask[i] <= 1'b0;
            state       <= S_XWAIT;
          end else begin
            if (cur_mask[i]) begin
              if (cnt == 2'd0) begin
                low <= i;
              end
              if (cnt != 2'd2) begin
                cnt <= cnt + 2'd1;
              end
            end
            if (scan_end) begin
              state <= S_DECIDE;
            end else begin
              i <= i + fpd_pkg::IDX_W'(1);
            end
          end
        end
        S_XWAIT: begin
          if (!eng_busy) begin
            state <= S_SCAN;
          end
        end
        S_DECIDE: begin
          if (cnt == 2'd0) begin
            if (peel_mode) begin
              state <= S_REMOVE;
            end else begin
              status_r <= fpd_pkg::ST_REDUNDANT;
              state    <= S_EMIT;
            end
          end else if (cnt == 2'd1) begin
            received_mask[low] <= 1'b1;
            held               <= held + fpd_pkg::PC_W'(1);
            if (peel_mode) begin
              progressed <= 1'b1;
            end
            state <= S_HOLD_WAIT;
          end else if (peel_mode) begin
            m     <= m + fpd_pkg::SLOT_W'(1);
            state <= S_PEEL_NEXT;
          end else if (queue_full) begin
            status_r <= fpd_pkg::ST_REDUNDANT;
            state    <= S_EMIT;
          end else begin
            mixed_used <= mixed_used + fpd_pkg::SLOT_W'(1);
            state      <= S_MOVE_WAIT;
          end
        end
        S_HOLD_WAIT: begin
          if (!eng_busy) begin
            if (peel_mode) begin
              state <= S_REMOVE;
            end else begin
              peel_mode <= 1'b1;
              state     <= S_PEEL_TOP;
            end
          end
        end
        S_PEEL_TOP: begin
          m          <= '0;
          progressed <= 1'b0;
          state      <= S_PEEL_NEXT;
        end
        S_PEEL_NEXT: begin
          if (m < mixed_used) begin
            state <= S_PEEL_LOAD;
          end else if (progressed) begin
            state <= S_PEEL_TOP;
          end else begin
            status_r <= complete ? fpd_pkg::ST_COMPLETE : fpd_pkg::ST_ACCEPTED;
            state    <= S_EMIT;
          end
        end
        S_PEEL_LOAD: begin
          cur_mask <= mm_rdata;
          i        <= '0;
          cnt      <= '0;
          cur_slot <= m;
          state    <= S_SCAN;
        end
        S_REMOVE: begin
          // drop slot m; fill the hole from the last slot
          mixed_used <= used_dec;
          if (m != used_dec) begin
            state <= S_REM_LOAD;
          end else begin
            state <= S_PEEL_NEXT;
          end
        end
        S_REM_LOAD: begin
          state <= S_MOVE_WAIT;
        end
        S_MOVE_WAIT: begin
          if (!eng_busy) begin
            if (peel_mode) begin
              state <= S_PEEL_NEXT;
            end else begin
              status_r <= complete ? fpd_pkg::ST_COMPLETE : fpd_pkg::ST_ACCEPTED;
              state    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            status    <= status_r;
            remaining <= pc_eff - held;
            read_byte <= rb_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
